>>> rtl/eiuf_pkg.sv
// eiuf_pkg: constants, configuration and result types for the ipv4/udp receive filter
// no dependencies; imported by every module of the filter
package eiuf_pkg;

    localparam int MAX_FRAME   = 2048;
    localparam int POS_W       = $clog2(MAX_FRAME + 1);
    localparam int OFS_W       = 7;
    localparam int LEN_W       = 12;
    localparam int MAC_W       = 48;
    localparam int IP_W        = 32;
    localparam int PORT_W      = 16;
    localparam int CFG_W       = 48;
    localparam int CFG_IDX_W   = 2;

    localparam int ETH_HDR_LEN = 14;
    localparam int UDP_HDR_LEN = 8;
    localparam int MAC_LEN     = 6;
    localparam int IP_DST_POS  = 30;
    localparam int IP_DST_END  = 33;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_PORT = 2'd2;

    typedef struct packed {
        logic [MAC_W-1:0]  local_mac;
        logic [IP_W-1:0]   local_ip;
        logic [PORT_W-1:0] local_port;
    } cfg_t;

    typedef struct packed {
        logic             accepted;
        logic [OFS_W-1:0] payload_offset;
        logic [LEN_W-1:0] frame_length;
    } result_t;

endpackage

>>> rtl/eiuf_cfg_regs.sv
// eiuf_cfg_regs: local mac, ip and port registers behind the plain write port
// depends on eiuf_pkg
module eiuf_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [eiuf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [eiuf_pkg::CFG_W-1:0]       cfg_data,
    output eiuf_pkg::cfg_t                   cfg
);
    import eiuf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LOCAL_MAC:  cfg_next.local_mac  = cfg_data[MAC_W-1:0];
                CFG_LOCAL_IP:   cfg_next.local_ip   = cfg_data[IP_W-1:0];
                CFG_LOCAL_PORT: cfg_next.local_port = cfg_data[PORT_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/eiuf_parse.sv
// eiuf_parse: per-frame header state and the single-pass compare logic for one byte
// depends on eiuf_pkg; the result is combinational and is registered by eiuf_out_reg
module eiuf_parse (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic [7:0]         frame_byte,
    input  logic               last_byte,
    input  eiuf_pkg::cfg_t     cfg,
    output eiuf_pkg::result_t  result
);
    import eiuf_pkg::*;

    localparam int CMP_W = (POS_W > OFS_W) ? POS_W : OFS_W;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             mac_match_reg, mac_match_next;
    logic             ip_match_reg, ip_match_next;
    logic [3:0]       hdr_words_reg, hdr_words_next;
    logic [7:0]       port_hi_reg, port_hi_next;
    logic             port_match_reg, port_match_next;

    logic             in_range;
    logic             past_eth;
    logic [7:0]       mac_want;
    logic [7:0]       ip_want;
    logic             at_mac;
    logic             at_ip;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] port_pos;

    always_comb begin
        case (pos_reg[2:0])
            3'd0:    mac_want = cfg.local_mac[47:40];
            3'd1:    mac_want = cfg.local_mac[39:32];
            3'd2:    mac_want = cfg.local_mac[31:24];
            3'd3:    mac_want = cfg.local_mac[23:16];
            3'd4:    mac_want = cfg.local_mac[15:8];
            3'd5:    mac_want = cfg.local_mac[7:0];
            default: mac_want = 8'h00;
        endcase
        // destination ip sits on bytes 30 to 33
        case (pos_reg[1:0])
            2'b10:   ip_want = cfg.local_ip[31:24];
            2'b11:   ip_want = cfg.local_ip[23:16];
            2'b00:   ip_want = cfg.local_ip[15:8];
            default: ip_want = cfg.local_ip[7:0];
        endcase
    end

    always_comb begin
        in_range = pos_reg < POS_W'(MAX_FRAME);
        past_eth = pos_reg > POS_W'(ETH_HDR_LEN);
        at_mac   = pos_reg < POS_W'(MAC_LEN);
        at_ip    = (pos_reg >= POS_W'(IP_DST_POS)) && (pos_reg <= POS_W'(IP_DST_END));
        pos_ext  = CMP_W'(pos_reg);
        port_pos = CMP_W'(ETH_HDR_LEN + 2) + CMP_W'({hdr_words_reg, 2'b00});

        pos_next        = pos_reg;
        mac_match_next  = mac_match_reg;
        ip_match_next   = ip_match_reg;
        hdr_words_next  = hdr_words_reg;
        port_hi_next    = port_hi_reg;
        port_match_next = port_match_reg;

        if (in_range) begin
            if (at_mac && (frame_byte != mac_want)) begin
                mac_match_next = 1'b0;
            end
            if (pos_reg == POS_W'(ETH_HDR_LEN)) begin
                hdr_words_next = frame_byte[3:0];
            end
            if (at_ip && (frame_byte != ip_want)) begin
                ip_match_next = 1'b0;
            end
            if (past_eth && (pos_ext == port_pos)) begin
                port_hi_next = frame_byte;
            end
            if (past_eth && (pos_ext == port_pos + CMP_W'(1))) begin
                port_match_next = {port_hi_reg, frame_byte} == cfg.local_port;
            end
            pos_next = pos_reg + POS_W'(1);
        end

        result.accepted       = mac_match_next && ip_match_next && port_match_next
                                && (pos_next > POS_W'(IP_DST_END));
        result.payload_offset = OFS_W'(ETH_HDR_LEN + UDP_HDR_LEN)
                                + {1'b0, hdr_words_next, 2'b00};
        result.frame_length   = LEN_W'(pos_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_byte)) begin
            pos_reg        <= '0;
            mac_match_reg  <= 1'b1;
            ip_match_reg   <= 1'b1;
            hdr_words_reg  <= '0;
            port_hi_reg    <= '0;
            port_match_reg <= 1'b0;
        end else if (step) begin
            pos_reg        <= pos_next;
            mac_match_reg  <= mac_match_next;
            ip_match_reg   <= ip_match_next;
            hdr_words_reg  <= hdr_words_next;
            port_hi_reg    <= port_hi_next;
            port_match_reg <= port_match_next;
        end
    end

endmodule

>>> rtl/eiuf_out_reg.sv
// eiuf_out_reg: result register with valid/ready on the result side
// depends on eiuf_pkg
module eiuf_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  eiuf_pkg::result_t  result_in,
    output logic               free,
    output logic               m_valid,
    input  logic               m_ready,
    output eiuf_pkg::result_t  result_out
);
    import eiuf_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result_in;
        end
    end

    assign m_valid    = valid_reg;
    assign result_out = data_reg;

endmodule

>>> rtl/eth_ipv4_udp_rx_filter.sv
// eth_ipv4_udp_rx_filter: mac, ipv4 destination and udp port filter for received frames
// one byte per cycle unless the input stage stalls; the last byte passes the input register, then the result register
// stages: input register, single-pass compare logic, result register
// the input stage stalls only when a last byte meets a full, unread result register
// synchronous active-low reset clears the configuration registers, frame state and both valid flags
// depends on eiuf_pkg, eiuf_cfg_regs, eiuf_parse, eiuf_out_reg
module eth_ipv4_udp_rx_filter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [eiuf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [eiuf_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_frame_byte,
    input  logic                            s_last_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_accepted,
    output logic [eiuf_pkg::OFS_W-1:0]      m_payload_offset,
    output logic [eiuf_pkg::LEN_W-1:0]      m_frame_length
);
    import eiuf_pkg::*;

    cfg_t    cfg;
    result_t parse_result;
    result_t out_result;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_free;
    logic       step;
    logic       s_xfer;

    eiuf_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // a byte moves on unless it closes a frame and the result register is held
    assign step    = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready = !in_valid_reg || step;
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_byte_reg <= s_frame_byte;
            in_last_reg <= s_last_byte;
        end
    end

    eiuf_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .frame_byte (in_byte_reg),
        .last_byte  (in_last_reg),
        .cfg        (cfg),
        .result     (parse_result)
    );

    eiuf_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (step && in_last_reg),
        .result_in  (parse_result),
        .free       (out_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result_out (out_result)
    );

    assign m_accepted       = out_result.accepted;
    assign m_payload_offset = out_result.payload_offset;
    assign m_frame_length   = out_result.frame_length;

endmodule

>>> sim/testbench.sv
// testbench: self-checking bench for the ipv4/udp receive filter, frames built byte by byte
// with random content, bursty sender, stalling receiver and a class-based frame scoreboard
// depends on eiuf_pkg and eth_ipv4_udp_rx_filter
module testbench;
    import eiuf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam bit [2:0] FLAW_NONE = 3'b000;
    localparam bit [2:0] FLAW_MAC  = 3'b001;
    localparam bit [2:0] FLAW_IP   = 3'b010;
    localparam bit [2:0] FLAW_PORT = 3'b100;

    localparam int HOLD_CYCLES = 400;

    class frame_scoreboard;
        logic [MAC_W-1:0]  local_mac;
        logic [IP_W-1:0]   local_ip;
        logic [PORT_W-1:0] local_port;
        logic [LEN_W-1:0]  byte_count;
        bit                mac_hit;
        bit                ip_hit;
        bit                port_hit;
        logic [3:0]        ihl;
        logic [7:0]        port_msb;
        result_t           verdicts[$];
        int                errors;

        function new();
            local_mac  = '0;
            local_ip   = '0;
            local_port = '0;
            errors     = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_count = '0;
            mac_hit    = 1'b1;
            ip_hit     = 1'b1;
            ihl        = '0;
            port_msb   = '0;
            port_hit   = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_LOCAL_MAC:  local_mac  = data[MAC_W-1:0];
                CFG_LOCAL_IP:   local_ip   = data[IP_W-1:0];
                CFG_LOCAL_PORT: local_port = data[PORT_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return verdicts.size();
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            int      pos;
            int      port_at;
            result_t v;
            pos = byte_count;
            if (pos < MAX_FRAME) begin
                port_at = ETH_HDR_LEN + ihl * 4 + 2;
                if (pos < MAC_LEN && b != local_mac[8 * (MAC_LEN - 1 - pos) +: 8])
                    mac_hit = 1'b0;
                if (pos == ETH_HDR_LEN)
                    ihl = b[3:0];
                if (pos >= IP_DST_POS && pos <= IP_DST_END
                        && b != local_ip[8 * (IP_DST_END - pos) +: 8])
                    ip_hit = 1'b0;
                if (pos > ETH_HDR_LEN && pos == port_at)
                    port_msb = b;
                if (pos > ETH_HDR_LEN && pos == port_at + 1)
                    port_hit = ({port_msb, b} == local_port);
                byte_count = LEN_W'(pos + 1);
            end
            if (last) begin
                v.accepted       = mac_hit && ip_hit && port_hit && (byte_count > IP_DST_END);
                v.payload_offset = OFS_W'(ETH_HDR_LEN + ihl * 4 + UDP_HDR_LEN);
                v.frame_length   = byte_count;
                verdicts.push_back(v);
                clear_frame();
            end
        endfunction

        task report_mismatch(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_verdict(result_t got);
            result_t want;
            if (verdicts.size() == 0) begin
                report_mismatch("result with no frame outstanding");
                return;
            end
            want = verdicts.pop_front();
            if (got.accepted !== want.accepted)
                report_mismatch($sformatf("accepted %0b, predicted %0b",
                                          got.accepted, want.accepted));
            if (got.payload_offset !== want.payload_offset)
                report_mismatch($sformatf("payload_offset %0d, predicted %0d",
                                          got.payload_offset, want.payload_offset));
            if (got.frame_length !== want.frame_length)
                report_mismatch($sformatf("frame_length %0d, predicted %0d",
                                          got.frame_length, want.frame_length));
        endtask
    endclass

    logic                 aclk             = 1'b0;
    logic                 aresetn          = 1'b0;
    logic                 cfg_wr_en        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index        = '0;
    logic [CFG_W-1:0]     cfg_data         = '0;
    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_frame_byte     = '0;
    logic                 s_last_byte      = 1'b0;
    logic                 m_valid;
    logic                 m_ready          = 1'b0;
    logic                 m_accepted;
    logic [OFS_W-1:0]     m_payload_offset;
    logic [LEN_W-1:0]     m_frame_length;

    frame_scoreboard sb = new();
    result_t         seen;

    int burst_left  = 0;
    int bytes_sent  = 0;
    int phase       = 0;
    int hold_token  = 0;
    int hold_ack    = 0;
    int hold_left   = 0;
    int ready_mode  = 0;
    int run_left    = 0;

    eth_ipv4_udp_rx_filter u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_frame_byte     (s_frame_byte),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_accepted       (m_accepted),
        .m_payload_offset (m_payload_offset),
        .m_frame_length   (m_frame_length)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result check before byte bookkeeping, so a stray result never meets a fresh verdict
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen.accepted       = m_accepted;
                seen.payload_offset = m_payload_offset;
                seen.frame_length   = m_frame_length;
                sb.check_verdict(seen);
            end
            if (s_valid && s_ready)
                sb.note_byte(s_frame_byte, s_last_byte);
        end
    end

    always @(posedge aclk) begin
        if (hold_token != hold_ack) begin
            hold_ack  <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            if (run_left == 0) begin
                ready_mode <= $urandom_range(0, 2);
                run_left   <= $urandom_range(10, 150);
            end else begin
                run_left <= run_left - 1;
            end
            case (ready_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= $urandom_range(0, 1);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic logic [CFG_W-1:0] pick_value(int width);
        logic [CFG_W-1:0] v;
        logic [CFG_W-1:0] mask;
        v    = CFG_W'({$urandom, $urandom});
        mask = '1;
        mask = mask >> (CFG_W - width);
        case ($urandom_range(0, 5))
            0:       v = v & ~mask;
            1:       v = v | mask;
            default: ;
        endcase
        return v;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge aclk);
    endtask

    task automatic send_byte(logic [7:0] b, logic last);
        s_valid      <= 1'b1;
        s_frame_byte <= b;
        s_last_byte  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic send_frame(int len, int ihl, bit [2:0] flaws, bit raw);
        logic [7:0] fb[];
        int         port_at;
        int         k;
        fb      = new[len];
        port_at = ETH_HDR_LEN + ihl * 4 + 2;
        foreach (fb[i])
            fb[i] = 8'($urandom_range(0, 255));
        if (!raw) begin
            for (int i = 0; i < MAC_LEN && i < len; i++)
                fb[i] = sb.local_mac[8 * (MAC_LEN - 1 - i) +: 8];
            if (len > ETH_HDR_LEN)
                fb[ETH_HDR_LEN] = {fb[ETH_HDR_LEN][7:4], 4'(ihl)};
            for (int i = IP_DST_POS; i <= IP_DST_END && i < len; i++)
                fb[i] = sb.local_ip[8 * (IP_DST_END - i) +: 8];
            if (port_at < len)
                fb[port_at] = sb.local_port[15:8];
            if (port_at + 1 < len)
                fb[port_at + 1] = sb.local_port[7:0];
            if (flaws & FLAW_MAC) begin
                k = $urandom_range(0, MAC_LEN - 1);
                if (k < len) fb[k] = fb[k] ^ 8'($urandom_range(1, 255));
            end
            if (flaws & FLAW_IP) begin
                k = $urandom_range(IP_DST_POS, IP_DST_END);
                if (k < len) fb[k] = fb[k] ^ 8'($urandom_range(1, 255));
            end
            if (flaws & FLAW_PORT) begin
                k = port_at + $urandom_range(0, 1);
                if (k < len) fb[k] = fb[k] ^ 8'($urandom_range(1, 255));
            end
        end
        for (int i = 0; i < len; i++)
            send_byte(fb[i], i == len - 1);
    endtask

    task automatic random_frame();
        int kind;
        int ihl;
        int len;
        int port_at;
        kind    = $urandom_range(0, 99);
        ihl     = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 5;
        port_at = ETH_HDR_LEN + ihl * 4 + 2;
        if (kind < 12)
            len = $urandom_range(1, port_at + 1);
        else
            len = $urandom_range(port_at + 2, port_at + 30);
        send_frame(len, ihl, (kind >= 12 && kind < 70) ? FLAW_NONE : 3'($urandom_range(0, 7)),
                   kind >= 92);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // registers still at reset
        send_frame(1, 5, FLAW_NONE, 1'b1);
        send_frame(6, 5, FLAW_NONE, 1'b0);
        send_frame(15, 7, FLAW_NONE, 1'b0);
        send_frame(33, 5, FLAW_NONE, 1'b0);
        send_frame(34, 0, FLAW_NONE, 1'b0);
        send_frame(42, 5, FLAW_NONE, 1'b0);
        send_frame(40, 4, FLAW_NONE, 1'b0);
        send_frame(78, 15, FLAW_NONE, 1'b0);
        send_frame(MAX_FRAME + 2, 5, FLAW_NONE, 1'b0);
        wait_idle();

        write_reg(CFG_LOCAL_MAC, '1);
        write_reg(CFG_LOCAL_IP, '1);
        write_reg(CFG_LOCAL_PORT, '1);
        write_reg(CFG_UNUSED, '0);
        send_frame(42, 5, FLAW_NONE, 1'b0);
        send_frame(42, 5, FLAW_MAC, 1'b0);
        send_frame(42, 5, FLAW_IP, 1'b0);
        send_frame(42, 5, FLAW_PORT, 1'b0);
        send_frame(41, 5, FLAW_NONE, 1'b0);
        wait_idle();

        bytes_sent = 0;
        while (bytes_sent < 1000) begin
            if ($urandom_range(0, 4) == 0)
                write_reg(CFG_UNUSED, pick_value(CFG_W));
            write_reg(CFG_LOCAL_MAC, pick_value(MAC_W));
            write_reg(CFG_LOCAL_IP, pick_value(IP_W));
            write_reg(CFG_LOCAL_PORT, pick_value(PORT_W));
            // in the first phase the receiver holds off while frames keep coming
            if (phase == 0)
                hold_token <= hold_token + 1;
            repeat ($urandom_range(4, 12)) begin
                random_frame();
            end
            wait_idle();
            phase++;
        end

        repeat (10) @(posedge aclk);
        if (sb.errors == 0)
            $display("eth_ipv4_udp_rx_filter: match");
        else
            $display("eth_ipv4_udp_rx_filter: mismatch");
        $finish;
    end

    initial begin
        #5000000;
        $display("eth_ipv4_udp_rx_filter: mismatch");
        $finish;
    end
endmodule

>>> eth_ipv4_udp_rx_filter.f
rtl/eiuf_pkg.sv
rtl/eiuf_cfg_regs.sv
rtl/eiuf_parse.sv
rtl/eiuf_out_reg.sv
rtl/eth_ipv4_udp_rx_filter.sv
sim/testbench.sv
